// ===== design/spag_pkg.sv =====
// Shared types, field widths and register indexes for the slot peak auto gain block.
package spag_pkg;

  localparam int PEAK_W = 15;
  localparam int STEP_W = 8;

  // configuration register indexes
  localparam logic [2:0] REG_ENABLED = 3'd0;
  localparam logic [2:0] REG_STEREO  = 3'd1;
  localparam logic [2:0] REG_FRAMES  = 3'd2;
  localparam logic [2:0] REG_HIGH    = 3'd3;
  localparam logic [2:0] REG_LOW     = 3'd4;
  localparam logic [2:0] REG_SILENCE = 3'd5;
  localparam logic [2:0] REG_STEP    = 3'd6;

  typedef struct packed {
    logic [PEAK_W-1:0]        slot_peak;
    logic                     recorded;
    logic signed [STEP_W-1:0] gain_step;
  } spag_result_t;

endpackage

// ===== design/spag_out_fifo.sv =====
// Three-entry result FIFO that decouples the ring update from the output handshake.
module spag_out_fifo
  import spag_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  spag_result_t push_data,
  input  logic         pop_ready,
  output logic         pop_valid,
  output spag_result_t pop_data,
  output logic [1:0]   count
);

  localparam logic [1:0] LAST_SLOT = 2'd2;
  localparam logic [1:0] FULL_CNT  = 2'd3;

  spag_result_t fifo_mem [3];
  logic [1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         pop;
  logic         push_ok;

  assign pop       = pop_valid & pop_ready;
  assign push_ok   = push & ((cnt_r != FULL_CNT) | pop);
  assign pop_valid = (cnt_r != 2'd0);
  assign pop_data  = fifo_mem[rd_ptr_r];
  assign count     = cnt_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? 2'd0 : wr_ptr_r + 2'd1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? 2'd0 : rd_ptr_r + 2'd1;
    end
    case ({push_ok, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      fifo_mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== design/slot_peak_auto_gain.sv =====
// A slot-closing frame's result is registered in the update stage, then written into the result FIFO, which offers it.
// Throughput: one frame per cycle while in_ready is high; a result beat may wait while new frames are taken.
// The ring lives in a one-port-read synchronous RAM; a high, low or silence level write
// starts a recount sweep over every ring entry, during which in_ready and cfg_ready are low.
// Reset (synchronous, rst_n low) empties the ring at once through per-entry valid bits
// and loads the configuration and control registers with their default values.
module slot_peak_auto_gain
  import spag_pkg::*;
#(
  parameter int SLOT_COUNT = 50
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [15:0]       in_left_sample,
  input  logic signed [15:0]       in_right_sample,
  input  logic                     in_buffer_end,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [PEAK_W-1:0]        out_slot_peak,
  output logic                     out_recorded,
  output logic signed [STEP_W-1:0] out_gain_step,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [2:0]               cfg_index,
  input  logic [15:0]              cfg_data
);

  localparam int POS_W    = $clog2(SLOT_COUNT);
  localparam int CNT_W    = $clog2(SLOT_COUNT + 1);
  localparam int UP_HI    = SLOT_COUNT / 10;
  localparam int UP_LO    = 2 * SLOT_COUNT / 3;
  localparam int DN_HI    = SLOT_COUNT / 5;
  localparam int DN_LO    = SLOT_COUNT / 3;

  localparam logic [1:0] CLS_NONE = 2'd0;
  localparam logic [1:0] CLS_HIGH = 2'd1;
  localparam logic [1:0] CLS_LOW  = 2'd2;

  localparam logic [6:0] STEP_MAX = 7'd100;

  // configuration
  logic              enabled_r;
  logic              stereo_r;
  logic [15:0]       frames_r;
  logic [PEAK_W-1:0] high_lvl_r;
  logic [PEAK_W-1:0] low_lvl_r;
  logic [PEAK_W-1:0] silence_r;
  logic [6:0]        step_pct_r;

  // ring and counts
  logic [PEAK_W-1:0]     ring_mem [SLOT_COUNT];
  logic [PEAK_W-1:0]     rdata_r;
  logic [SLOT_COUNT-1:0] valid_r, valid_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt, pos_inc;
  logic [CNT_W-1:0]      high_cnt_r, high_cnt_nxt;
  logic [CNT_W-1:0]      low_cnt_r, low_cnt_nxt;
  logic [POS_W-1:0]      rd_addr;

  // recount sweep
  logic             sw_act_r;
  logic [POS_W-1:0] sw_idx_r;
  logic             sw_dv_r;
  logic [POS_W-1:0] sw_didx_r;
  logic             busy;

  // frame stage
  logic [PEAK_W-1:0] run_peak_r;
  logic [15:0]       frame_cnt_r;
  logic [PEAK_W-1:0] mag_l, mag_r, peak_new;
  logic [15:0]       limit;
  logic [16:0]       frame_next;
  logic              close;
  logic              in_fire;
  logic              cfg_fire;
  logic              thr_write;

  // ring update stage
  logic              b_v_r;
  logic [PEAK_W-1:0] b_peak_r;
  logic              b_rec;
  logic              b_step;
  logic [PEAK_W-1:0] old_val;
  logic [PEAK_W-1:0] sw_val;
  logic [1:0]        old_cls, new_cls, sw_cls;
  logic [CNT_W-1:0]  h_upd, l_upd;
  logic              go_up, go_down;
  logic [6:0]        step_sat;
  logic signed [STEP_W-1:0] step_val;

  spag_result_t res_push, res_pop;
  logic [1:0]   fifo_cnt;

  function automatic logic [1:0] classify(input logic [PEAK_W-1:0] v,
                                          input logic [PEAK_W-1:0] hi,
                                          input logic [PEAK_W-1:0] lo);
    logic [1:0] c;
    c = CLS_NONE;
    if (v > hi) begin
      c = CLS_HIGH;
    end else if ((v != '0) && (v < lo)) begin
      c = CLS_LOW;
    end
    return c;
  endfunction

  assign busy      = sw_act_r | sw_dv_r;
  assign cfg_ready = ~busy;
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign thr_write = cfg_fire &
                     ((cfg_index == REG_HIGH) || (cfg_index == REG_LOW) ||
                      (cfg_index == REG_SILENCE));

  // room for the beat in the update stage plus this one
  assign in_ready = ~busy & (({1'b0, fifo_cnt} + {2'b00, b_v_r}) <= 3'd2);
  assign in_fire  = in_valid & in_ready;

  // one's-complement magnitude
  assign mag_l = in_left_sample[15]  ? ~in_left_sample[14:0]  : in_left_sample[14:0];
  assign mag_r = in_right_sample[15] ? ~in_right_sample[14:0] : in_right_sample[14:0];

  always_comb begin
    peak_new = run_peak_r;
    if (mag_l > peak_new) begin
      peak_new = mag_l;
    end
    if (stereo_r && (mag_r > peak_new)) begin
      peak_new = mag_r;
    end
  end

  assign limit      = (frames_r == 16'd0) ? 16'd1 : frames_r;
  assign frame_next = {1'b0, frame_cnt_r} + 17'd1;
  assign close      = in_buffer_end | (frame_next >= {1'b0, limit});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_peak_r  <= '0;
      frame_cnt_r <= 16'd0;
      b_v_r       <= 1'b0;
    end else begin
      b_v_r <= in_fire & close;
      if (in_fire) begin
        if (close) begin
          run_peak_r  <= '0;
          frame_cnt_r <= 16'd0;
        end else begin
          run_peak_r  <= peak_new;
          frame_cnt_r <= frame_next[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_peak_r <= peak_new;
    end
  end

  // ring update: entry at pos_r arrives from RAM this cycle
  assign pos_inc  = (pos_r == POS_W'(SLOT_COUNT - 1)) ? '0 : pos_r + 1'b1;
  assign b_rec    = b_v_r & enabled_r & (b_peak_r >= silence_r);
  assign old_val  = valid_r[pos_r] ? rdata_r : '0;
  assign old_cls  = classify(old_val, high_lvl_r, low_lvl_r);
  assign new_cls  = classify(b_peak_r, high_lvl_r, low_lvl_r);
  assign sw_val   = valid_r[sw_didx_r] ? rdata_r : '0;
  assign sw_cls   = classify(sw_val, high_lvl_r, low_lvl_r);
  assign step_sat = (step_pct_r > STEP_MAX) ? STEP_MAX : step_pct_r;

  always_comb begin
    h_upd = high_cnt_r;
    l_upd = low_cnt_r;
    if ((old_cls == CLS_HIGH) && (h_upd != '0)) begin
      h_upd = h_upd - 1'b1;
    end else if ((old_cls == CLS_LOW) && (l_upd != '0)) begin
      l_upd = l_upd - 1'b1;
    end
    if (new_cls == CLS_HIGH) begin
      h_upd = h_upd + 1'b1;
    end else if (new_cls == CLS_LOW) begin
      l_upd = l_upd + 1'b1;
    end
  end

  assign go_up   = (h_upd <= CNT_W'(UP_HI)) && (l_upd > CNT_W'(UP_LO));
  assign go_down = ~go_up && (h_upd > CNT_W'(DN_HI)) && (l_upd < CNT_W'(DN_LO));
  assign b_step  = b_rec & (go_up | go_down);

  always_comb begin
    step_val = '0;
    if (b_rec && go_up) begin
      step_val = $signed({1'b0, step_sat});
    end else if (b_rec && go_down) begin
      step_val = STEP_W'(0) - $signed({1'b0, step_sat});
    end
  end

  always_comb begin
    valid_nxt    = valid_r;
    pos_nxt      = pos_r;
    high_cnt_nxt = high_cnt_r;
    low_cnt_nxt  = low_cnt_r;
    if (thr_write) begin
      high_cnt_nxt = '0;
      low_cnt_nxt  = '0;
    end else if (sw_dv_r) begin
      if (sw_cls == CLS_HIGH) begin
        high_cnt_nxt = high_cnt_r + 1'b1;
      end else if (sw_cls == CLS_LOW) begin
        low_cnt_nxt = low_cnt_r + 1'b1;
      end
    end else if (b_rec) begin
      if (b_step) begin
        valid_nxt    = '0;
        pos_nxt      = '0;
        high_cnt_nxt = '0;
        low_cnt_nxt  = '0;
      end else begin
        valid_nxt[pos_r] = 1'b1;
        pos_nxt          = pos_inc;
        high_cnt_nxt     = h_upd;
        low_cnt_nxt      = l_upd;
      end
    end
  end

  // after a clearing step the entry at zero reads as empty, so no need to steer on it
  assign rd_addr = sw_act_r ? sw_idx_r : (b_rec ? pos_inc : pos_r);

  always_ff @(posedge clk) begin
    if (b_rec) begin
      ring_mem[pos_r] <= b_peak_r;
    end
    rdata_r <= ring_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      pos_r      <= '0;
      high_cnt_r <= '0;
      low_cnt_r  <= '0;
      sw_act_r   <= 1'b0;
      sw_idx_r   <= '0;
      sw_dv_r    <= 1'b0;
      sw_didx_r  <= '0;
    end else begin
      valid_r    <= valid_nxt;
      pos_r      <= pos_nxt;
      high_cnt_r <= high_cnt_nxt;
      low_cnt_r  <= low_cnt_nxt;
      sw_dv_r    <= sw_act_r;
      sw_didx_r  <= sw_idx_r;
      if (thr_write) begin
        sw_act_r <= 1'b1;
        sw_idx_r <= '0;
      end else if (sw_act_r) begin
        if (sw_idx_r == POS_W'(SLOT_COUNT - 1)) begin
          sw_act_r <= 1'b0;
        end else begin
          sw_idx_r <= sw_idx_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r  <= 1'b0;
      stereo_r   <= 1'b1;
      frames_r   <= 16'd4410;
      high_lvl_r <= 15'd29000;
      low_lvl_r  <= 15'd8000;
      silence_r  <= 15'd300;
      step_pct_r <= 7'd5;
    end else if (cfg_fire) begin
      case (cfg_index)
        REG_ENABLED: enabled_r  <= cfg_data[0];
        REG_STEREO:  stereo_r   <= cfg_data[0];
        REG_FRAMES:  frames_r   <= cfg_data;
        REG_HIGH:    high_lvl_r <= cfg_data[14:0];
        REG_LOW:     low_lvl_r  <= cfg_data[14:0];
        REG_SILENCE: silence_r  <= cfg_data[14:0];
        REG_STEP:    step_pct_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign res_push.slot_peak = b_peak_r;
  assign res_push.recorded  = b_rec;
  assign res_push.gain_step = step_val;

  spag_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (b_v_r),
    .push_data (res_push),
    .pop_ready (out_ready),
    .pop_valid (out_valid),
    .pop_data  (res_pop),
    .count     (fifo_cnt)
  );

  assign out_slot_peak = res_pop.slot_peak;
  assign out_recorded  = res_pop.recorded;
  assign out_gain_step = res_pop.gain_step;

  a_no_beat_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> !sw_act_r && !sw_dv_r)
    else $error("input beat taken during recount sweep");

  a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, high_cnt_r} + {1'b0, low_cnt_r}) <= (CNT_W + 1)'(SLOT_COUNT))
    else $error("high and low counts exceed ring size");

  a_step_clears: assert property (@(posedge clk) disable iff (!rst_n)
    b_step |=> (pos_r == '0) && (valid_r == '0) && (high_cnt_r == '0) && (low_cnt_r == '0))
    else $error("gain step did not clear the ring");

  a_thr_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    thr_write |=> sw_act_r && (sw_idx_r == '0) && (high_cnt_r == '0))
    else $error("threshold write did not start a recount");

  a_no_fifo_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    b_v_r |-> (fifo_cnt != 2'd3) || out_ready)
    else $error("result pushed into full FIFO");

endmodule

// ===== test/tb.sv =====
// Self-checking bench for slot_peak_auto_gain with a built-in slot and gain predictor.
`timescale 1ns / 1ps

module tb
  import spag_pkg::*;
();

  localparam int SLOTS = 50;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 6;

  // index past the end of the register list, must be ignored
  localparam logic [2:0] REG_UNUSED_IDX = 3'd7;

  typedef enum int {LEVEL_NONE, LEVEL_HIGH, LEVEL_LOW} level_t;
  typedef enum int {MIX_ANY, MIX_LOW, MIX_HIGH, MIX_QUIET} mix_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [15:0]       in_left_sample = '0;
  logic signed [15:0]       in_right_sample = '0;
  logic                     in_buffer_end = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [PEAK_W-1:0]        out_slot_peak;
  logic                     out_recorded;
  logic signed [STEP_W-1:0] out_gain_step;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [2:0]               cfg_index = '0;
  logic [15:0]              cfg_data = '0;

  slot_peak_auto_gain #(.SLOT_COUNT(SLOTS)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_left_sample  (in_left_sample),
    .in_right_sample (in_right_sample),
    .in_buffer_end   (in_buffer_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_slot_peak   (out_slot_peak),
    .out_recorded    (out_recorded),
    .out_gain_step   (out_gain_step),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor copy of registers and state
  logic        agc_on;
  logic        use_right;
  logic [15:0] slot_len;
  logic [14:0] high_lvl;
  logic [14:0] low_lvl;
  logic [14:0] quiet_lvl;
  logic [6:0]  step_pct;
  logic [14:0] ring [SLOTS];
  int          ring_pos;
  int          n_high;
  int          n_low;
  logic [14:0] open_peak;
  logic [15:0] open_frames;

  spag_result_t closed_slots[$];
  spag_result_t head_slot;

  bit steady = 1'b0;
  int mismatches = 0;
  int frames_sent = 0;
  int slots_seen = 0;
  int peaks_kept = 0;
  int steps_up = 0;
  int steps_down = 0;
  int quiet_cycles = 0;

  function automatic level_t level_of(logic [14:0] v);
    if (v > high_lvl) return LEVEL_HIGH;
    if (v != 0 && v < low_lvl) return LEVEL_LOW;
    return LEVEL_NONE;
  endfunction

  function automatic void empty_ring();
    foreach (ring[i]) ring[i] = '0;
    ring_pos = 0;
    n_high = 0;
    n_low = 0;
  endfunction

  function automatic void tally_ring();
    n_high = 0;
    n_low = 0;
    foreach (ring[i]) begin
      case (level_of(ring[i]))
        LEVEL_HIGH: n_high++;
        LEVEL_LOW:  n_low++;
        default: ;
      endcase
    end
  endfunction

  function automatic void load_defaults();
    agc_on = 1'b0;
    use_right = 1'b1;
    slot_len = 16'd4410;
    high_lvl = 15'd29000;
    low_lvl = 15'd8000;
    quiet_lvl = 15'd300;
    step_pct = 7'd5;
    empty_ring();
    open_peak = '0;
    open_frames = '0;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [15:0] val);
    case (idx)
      REG_ENABLED: agc_on = val[0];
      REG_STEREO:  use_right = val[0];
      REG_FRAMES:  slot_len = val;
      REG_HIGH: begin
        high_lvl = val[14:0];
        tally_ring();
      end
      REG_LOW: begin
        low_lvl = val[14:0];
        tally_ring();
      end
      REG_SILENCE: begin
        quiet_lvl = val[14:0];
        tally_ring();
      end
      REG_STEP:    step_pct = val[6:0];
      default: ;
    endcase
  endfunction

  // one's-complement magnitude: negative samples fold with k xor sign
  function automatic logic [14:0] sample_mag(logic signed [15:0] s);
    return s[15] ? ~s[14:0] : s[14:0];
  endfunction

  function automatic void advance_slot(logic signed [15:0] l, logic signed [15:0] r,
                                       logic be);
    spag_result_t res;
    logic [15:0]  lim;
    int           sp;
    int           step;
    lim = (slot_len == 16'd0) ? 16'd1 : slot_len;
    if (sample_mag(l) > open_peak) open_peak = sample_mag(l);
    if (use_right && sample_mag(r) > open_peak) open_peak = sample_mag(r);
    open_frames++;
    if (!be && open_frames < lim) return;
    res.slot_peak = open_peak;
    res.recorded = 1'b0;
    step = 0;
    open_peak = '0;
    open_frames = '0;
    if (agc_on && res.slot_peak >= quiet_lvl) begin
      case (level_of(ring[ring_pos]))
        LEVEL_HIGH: if (n_high > 0) n_high--;
        LEVEL_LOW:  if (n_low > 0) n_low--;
        default: ;
      endcase
      ring[ring_pos] = res.slot_peak;
      case (level_of(res.slot_peak))
        LEVEL_HIGH: n_high++;
        LEVEL_LOW:  n_low++;
        default: ;
      endcase
      ring_pos = (ring_pos + 1) % SLOTS;
      res.recorded = 1'b1;
      peaks_kept++;
      sp = (step_pct > 7'd100) ? 100 : int'(step_pct);
      if (n_high <= SLOTS / 10 && n_low > 2 * SLOTS / 3) begin
        step = sp;
        steps_up++;
        empty_ring();
      end else if (n_high > SLOTS / 5 && n_low < SLOTS / 3) begin
        step = -sp;
        steps_down++;
        empty_ring();
      end
    end
    res.gain_step = step[STEP_W-1:0];
    closed_slots.push_back(res);
  endfunction

  // result side: check each beat, then pick the next ready level
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (closed_slots.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result beat, expected none, got peak %0d", $time,
                 out_slot_peak);
      end else begin
        head_slot = closed_slots.pop_front();
        slots_seen++;
        if (out_slot_peak !== head_slot.slot_peak) begin
          mismatches++;
          $display("%0t: slot_peak expected %0d, got %0d", $time, head_slot.slot_peak,
                   out_slot_peak);
        end
        if (out_recorded !== head_slot.recorded) begin
          mismatches++;
          $display("%0t: recorded expected %0d, got %0d", $time, head_slot.recorded,
                   out_recorded);
        end
        if (out_gain_step !== head_slot.gain_step) begin
          mismatches++;
          $display("%0t: gain_step expected %0d, got %0d", $time, head_slot.gain_step,
                   out_gain_step);
        end
      end
    end
    out_ready <= steady || ($urandom_range(99) >= 38);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_frame(input logic signed [15:0] l, input logic signed [15:0] r,
                            input logic be);
    while (!steady && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_left_sample <= l;
    in_right_sample <= r;
    in_buffer_end <= be;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_slot(l, r, be);
    frames_sent++;
  endtask

  // wait for every expected slot and for frames that closed nothing to clear the pipe
  task automatic settle();
    in_valid <= 1'b0;
    while (closed_slots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [14:0] pick_mag(mix_t mix);
    int r;
    int base;
    int v;
    r = $urandom_range(99);
    base = (quiet_lvl == 0) ? 1 : int'(quiet_lvl);
    v = $urandom_range(32767, 0);
    if (mix == MIX_LOW && r < 90 && int'(low_lvl) > base)
      v = $urandom_range(int'(low_lvl) - 1, base);
    else if (mix == MIX_HIGH && r < 85 && high_lvl != 15'h7FFF)
      v = $urandom_range(32767, int'(high_lvl) + 1);
    else if (mix == MIX_QUIET && r < 85 && quiet_lvl != 0)
      v = $urandom_range(int'(quiet_lvl) - 1, 0);
    return v[14:0];
  endfunction

  function automatic logic signed [15:0] as_sample(logic [14:0] m);
    return $urandom_range(1) ? ~{1'b0, m} : {1'b0, m};
  endfunction

  // level register value; bit 15 carries junk that the block must drop
  function automatic logic [15:0] pick_level(int lo, int hi);
    int r;
    int v;
    int j;
    r = $urandom_range(9);
    j = $urandom;
    v = $urandom_range(hi, lo);
    if (r == 0) v = 0;
    if (r == 1) v = 32767;
    return {j[15], v[14:0]};
  endfunction

  task automatic run_frames(input mix_t mix, input int count, input int end_pct);
    for (int i = 0; i < count; i++)
      send_frame(as_sample(pick_mag(mix)), as_sample(pick_mag(mix)),
                 $urandom_range(99) < end_pct);
  endtask

  task automatic program_phase(input logic on, input logic stereo_on, input logic [15:0] len,
                               input logic [15:0] hi, input logic [15:0] lo,
                               input logic [15:0] sil, input logic [6:0] step);
    int j;
    j = $urandom;
    settle();
    write_reg(REG_ENABLED, {j[15:1], on});
    write_reg(REG_STEREO, {j[30:16], stereo_on});
    write_reg(REG_FRAMES, len);
    write_reg(REG_HIGH, hi);
    write_reg(REG_LOW, lo);
    write_reg(REG_SILENCE, sil);
    write_reg(REG_STEP, {j[24:16], step});
    if (j[31]) write_reg(REG_UNUSED_IDX, j[15:0]);
  endtask

  // disabled after reset: slots close on buffer end and report peaks, nothing recorded
  task automatic test_reset_defaults();
    send_frame(16'sd32767, -16'sd32768, 1'b1);
    send_frame(-16'sd1, 16'sd0, 1'b0);
    send_frame(16'sd0, -16'sd1, 1'b1);
    send_frame(-16'sd32768, 16'sd5, 1'b0);
    send_frame(16'sd100, -16'sd200, 1'b1);
  endtask

  // mono, one frame per slot, masked wide writes, spare index, saturated step down
  task automatic test_mono_saturated_step();
    settle();
    write_reg(REG_ENABLED, 16'hFFFF);
    write_reg(REG_STEREO, 16'hFFFE);
    write_reg(REG_FRAMES, 16'd0);
    write_reg(REG_STEP, 16'hFF7F);
    write_reg(REG_SILENCE, 16'h812C);
    write_reg(REG_UNUSED_IDX, 16'hFFFF);
    send_frame(16'sd1000, 16'sd32767, 1'b0);
    send_frame(16'sd250, -16'sd32768, 1'b0);
    send_frame(-16'sd32768, 16'sd0, 1'b1);
    send_frame(-16'sd1, -16'sd1, 1'b0);
    repeat (10) send_frame(16'sd32767, 16'sd0, 1'b0);
  endtask

  task automatic test_random_traffic();
    mix_t        mix;
    logic [15:0] len;
    logic [15:0] hi;
    logic [15:0] lo;
    logic [15:0] sil;
    logic [6:0]  step;
    int          end_pct;
    for (int p = 0; p < 11; p++) begin
      case (p % 3)
        0:       mix = MIX_LOW;
        1:       mix = MIX_HIGH;
        default: mix = MIX_ANY;
      endcase
      if (p == 9) mix = MIX_QUIET;
      case (p % 4)
        0:       len = 16'd0;
        1:       len = 16'd1;
        2:       len = 16'($urandom_range(4, 2));
        default: len = 16'hFFFF;
      endcase
      end_pct = (len == 16'hFFFF) ? 25 : 8;
      case (p)
        2:       step = 7'd0;
        4:       step = 7'd100;
        7:       step = 7'd127;
        default: step = 7'($urandom_range(30, 1));
      endcase
      hi = pick_level(20000, 31000);
      lo = pick_level(3000, 15000);
      sil = pick_level(0, 1000);
      if (p == 1) sil = 16'd0;
      if (p == 8) begin
        hi = 16'h7FFF;
        lo = 16'h0000;
      end
      if (p == 10) begin
        hi = 16'h0000;
        lo = 16'h7FFF;
        sil = 16'h7FFF;
      end
      program_phase(p != 5, 1'($urandom_range(1)), len, hi, lo, sil, step);
      run_frames(mix, 150, end_pct);
    end
  endtask

  // long stretch with both sides always ready
  task automatic test_back_to_back();
    program_phase(1'b1, 1'b1, 16'd1, 16'd25000, 16'd6000, 16'd200, 7'd10);
    steady = 1'b1;
    run_frames(MIX_HIGH, 80, 10);
    run_frames(MIX_LOW, 80, 10);
    settle();
    steady = 1'b0;
  endtask

  initial begin
    load_defaults();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_mono_saturated_step();
    test_random_traffic();
    test_back_to_back();
    settle();
    $display("Ran %0d frames into %0d slot results, %0d peaks entered the ring", frames_sent,
             slots_seen, peaks_kept);
    $display("Gain decisions: %0d up, %0d down, %0d mismatches", steps_up, steps_down,
             mismatches);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
